>>> rtl/fpa_pkg.sv
// Shared types, constants and operation codes for the fixed-point ALU.
// No dependencies; every other file of the block imports this package.
package fpa_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        FN_ADD      = 4'd0,
        FN_SUB      = 4'd1,
        FN_MUL      = 4'd2,
        FN_DIV      = 4'd3,
        FN_MIN      = 4'd4,
        FN_MAX      = 4'd5,
        FN_INC      = 4'd6,
        FN_DEC      = 4'd7,
        FN_FROM_INT = 4'd8,
        FN_TO_INT   = 4'd9,
        FN_COMPARE  = 4'd10
    } t_func;

    typedef struct packed {
        t_func                       func;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
    } t_alu_req;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result_value;
        logic                        greater;
        logic                        less;
        logic                        equal;
        logic                        overflow;
        logic                        divide_by_zero;
    } t_alu_rsp;

    // Control that travels with every request down the pipeline.
    typedef struct packed {
        logic  valid;
        t_func func;
        logic  neg;
        logic  a_neg;
        logic  b_zero;
    } t_meta;

endpackage

>>> rtl/fixed_point_alu_unit.sv
// Top level of the signed fixed-point ALU: a fixed-latency pipeline.
// Depends on fpa_pkg and the divider pipeline fpa_div.

// A request is taken at every clock edge with start high; busy never rises, so one
// request per cycle is sustained. Every operation leaves the pipeline after the same
// latency, set by the divider, which resolves one quotient bit per stage; the default
// format is Q24.8. Results come out in request order with o_valid high for one cycle
// and must be captured then, since the receiver cannot stall the pipeline.
module fixed_point_alu_unit
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_alu_req i_req,
    output logic     o_valid,
    output t_alu_rsp o_rsp
);

    localparam int NUM_BITS = WORD_BITS + FRAC_BITS;
    localparam int DLY      = NUM_BITS - 2;
    localparam int LAT      = NUM_BITS + 2;
    localparam int PROD     = 2 * WORD_BITS;

    assign busy = 1'b0;

    // Stage 1: capture operands and magnitudes.
    t_meta                       r_s1_meta, n_s1_meta;
    logic signed [WORD_BITS-1:0] r_s1_a, r_s1_b;
    logic [WORD_BITS-1:0]        r_s1_amag, r_s1_bmag;

    always_comb begin
        n_s1_meta.valid  = start && !busy;
        n_s1_meta.func   = i_req.func;
        n_s1_meta.neg    = i_req.operand_a[WORD_BITS-1] ^ i_req.operand_b[WORD_BITS-1];
        n_s1_meta.a_neg  = i_req.operand_a[WORD_BITS-1];
        n_s1_meta.b_zero = i_req.operand_b == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_meta.valid <= 1'b0;
        end else begin
            r_s1_meta.valid <= n_s1_meta.valid;
        end
        r_s1_meta.func   <= n_s1_meta.func;
        r_s1_meta.neg    <= n_s1_meta.neg;
        r_s1_meta.a_neg  <= n_s1_meta.a_neg;
        r_s1_meta.b_zero <= n_s1_meta.b_zero;
        r_s1_a    <= i_req.operand_a;
        r_s1_b    <= i_req.operand_b;
        r_s1_amag <= i_req.operand_a[WORD_BITS-1] ? WORD_BITS'(-i_req.operand_a)
                                                  : i_req.operand_a;
        r_s1_bmag <= i_req.operand_b[WORD_BITS-1] ? WORD_BITS'(-i_req.operand_b)
                                                  : i_req.operand_b;
    end

    // Stage 2: product of magnitudes, and every operation other than multiply and divide.
    t_meta               r_s2_meta;
    logic [PROD-1:0]     r_s2_prod;
    t_alu_rsp            r_s2_res, n_s2_res;

    logic signed [WORD_BITS:0]   c_sum;
    logic signed [NUM_BITS-1:0]  c_fix;
    logic                        c_fits;

    always_comb begin
        n_s2_res = '0;
        c_sum    = '0;
        c_fix    = NUM_BITS'(r_s1_a) <<< FRAC_BITS;
        c_fits   = 1'b1;
        unique case (r_s1_meta.func)
            FN_ADD:  c_sum = {r_s1_a[WORD_BITS-1], r_s1_a} + {r_s1_b[WORD_BITS-1], r_s1_b};
            FN_SUB:  c_sum = {r_s1_a[WORD_BITS-1], r_s1_a} - {r_s1_b[WORD_BITS-1], r_s1_b};
            FN_INC:  c_sum = {r_s1_a[WORD_BITS-1], r_s1_a} + (WORD_BITS+1)'(1);
            FN_DEC:  c_sum = {r_s1_a[WORD_BITS-1], r_s1_a} - (WORD_BITS+1)'(1);
            default: c_sum = '0;
        endcase
        unique case (r_s1_meta.func)
            FN_ADD, FN_SUB, FN_INC, FN_DEC: begin
                c_fits = c_sum[WORD_BITS] == c_sum[WORD_BITS-1];
                n_s2_res.result_value = c_fits ? c_sum[WORD_BITS-1:0]
                                      : (c_sum[WORD_BITS] ? WORD_MIN : WORD_MAX);
                n_s2_res.overflow = !c_fits;
            end
            FN_MIN: n_s2_res.result_value = (r_s1_b < r_s1_a) ? r_s1_b : r_s1_a;
            FN_MAX: n_s2_res.result_value = (r_s1_a < r_s1_b) ? r_s1_b : r_s1_a;
            FN_FROM_INT: begin
                c_fits = (c_fix[NUM_BITS-1:WORD_BITS-1] == '0)
                      || (c_fix[NUM_BITS-1:WORD_BITS-1] == '1);
                n_s2_res.result_value = c_fits ? c_fix[WORD_BITS-1:0]
                                      : (c_fix[NUM_BITS-1] ? WORD_MIN : WORD_MAX);
                n_s2_res.overflow = !c_fits;
            end
            FN_TO_INT: n_s2_res.result_value = r_s1_a >>> FRAC_BITS;
            FN_COMPARE: begin
                n_s2_res.greater = r_s1_b < r_s1_a;
                n_s2_res.less    = r_s1_a < r_s1_b;
                n_s2_res.equal   = r_s1_a == r_s1_b;
            end
            default: n_s2_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_meta.valid <= 1'b0;
        end else begin
            r_s2_meta.valid <= r_s1_meta.valid;
        end
        r_s2_meta.func   <= r_s1_meta.func;
        r_s2_meta.neg    <= r_s1_meta.neg;
        r_s2_meta.a_neg  <= r_s1_meta.a_neg;
        r_s2_meta.b_zero <= r_s1_meta.b_zero;
        r_s2_prod <= PROD'(r_s1_amag) * PROD'(r_s1_bmag);
        r_s2_res  <= n_s2_res;
    end

    // Stage 3: sign, scale and saturate the product.
    t_meta    r_s3_meta;
    t_alu_rsp r_s3_res, n_s3_res;

    logic signed [PROD:0] c_prod;
    logic signed [PROD:0] c_scaled;
    logic                 c_mfits;

    always_comb begin
        c_prod   = r_s2_meta.neg ? -$signed({1'b0, r_s2_prod}) : $signed({1'b0, r_s2_prod});
        c_scaled = c_prod >>> FRAC_BITS;
        c_mfits  = (c_scaled[PROD:WORD_BITS-1] == '0) || (c_scaled[PROD:WORD_BITS-1] == '1);
        n_s3_res = r_s2_res;
        if (r_s2_meta.func == FN_MUL) begin
            n_s3_res = '0;
            n_s3_res.result_value = c_mfits ? c_scaled[WORD_BITS-1:0]
                                  : (c_scaled[PROD] ? WORD_MIN : WORD_MAX);
            n_s3_res.overflow = !c_mfits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_meta.valid <= 1'b0;
        end else begin
            r_s3_meta.valid <= r_s2_meta.valid;
        end
        r_s3_meta.func   <= r_s2_meta.func;
        r_s3_meta.neg    <= r_s2_meta.neg;
        r_s3_meta.a_neg  <= r_s2_meta.a_neg;
        r_s3_meta.b_zero <= r_s2_meta.b_zero;
        r_s3_res <= n_s3_res;
    end

    // Delay line that keeps the other results aligned with the divider.
    t_meta    r_dly_meta [DLY];
    t_alu_rsp r_dly_res  [DLY];

    for (genvar k = 0; k < DLY; k++) begin : g_dly
        t_meta    c_in_meta;
        t_alu_rsp c_in_res;
        if (k == 0) begin : g_head
            assign c_in_meta = r_s3_meta;
            assign c_in_res  = r_s3_res;
        end else begin : g_body
            assign c_in_meta = r_dly_meta[k-1];
            assign c_in_res  = r_dly_res[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dly_meta[k].valid <= 1'b0;
            end else begin
                r_dly_meta[k].valid <= c_in_meta.valid;
            end
            r_dly_meta[k].func   <= c_in_meta.func;
            r_dly_meta[k].neg    <= c_in_meta.neg;
            r_dly_meta[k].a_neg  <= c_in_meta.a_neg;
            r_dly_meta[k].b_zero <= c_in_meta.b_zero;
            r_dly_res[k] <= c_in_res;
        end
    end

    logic [NUM_BITS-1:0] c_quot;

    fpa_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_dividend (r_s1_amag),
        .i_divisor  (r_s1_bmag),
        .o_quot     (c_quot)
    );

    // Output stage: finish the quotient or pass the aligned result.
    t_meta                    c_last;
    t_alu_rsp                 n_out_rsp;
    logic signed [NUM_BITS:0] c_q;
    logic                     c_qfits;
    logic                     r_out_valid;
    t_alu_rsp                 r_out_rsp;

    assign c_last = r_dly_meta[DLY-1];

    always_comb begin
        c_q       = c_last.neg ? -$signed({1'b0, c_quot}) : $signed({1'b0, c_quot});
        c_qfits   = (c_q[NUM_BITS:WORD_BITS-1] == '0) || (c_q[NUM_BITS:WORD_BITS-1] == '1);
        n_out_rsp = r_dly_res[DLY-1];
        if (c_last.func == FN_DIV) begin
            n_out_rsp = '0;
            if (c_last.b_zero) begin
                n_out_rsp.result_value   = c_last.a_neg ? WORD_MIN : WORD_MAX;
                n_out_rsp.divide_by_zero = 1'b1;
            end else begin
                n_out_rsp.result_value = c_qfits ? c_q[WORD_BITS-1:0]
                                       : (c_q[NUM_BITS] ? WORD_MIN : WORD_MAX);
                n_out_rsp.overflow = !c_qfits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= c_last.valid;
        end
        r_out_rsp <= n_out_rsp;
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out_rsp;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("request did not complete after the pipeline latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without a matching request");

    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_rsp.greater, o_rsp.less, o_rsp.equal}))
        else $error("more than one compare flag set");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.greater || o_rsp.less || o_rsp.equal))
        |-> (o_rsp.result_value == '0 && !o_rsp.overflow))
        else $error("compare result carries a value");

    a_dz_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.divide_by_zero) |-> !o_rsp.overflow)
        else $error("divide by zero also flagged overflow");

endmodule

>>> rtl/fpa_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on fpa_pkg for the word width.
module fpa_div
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic [WORD_BITS-1:0]           i_dividend,
    input  logic [WORD_BITS-1:0]           i_divisor,
    output logic [WORD_BITS+FRAC_BITS-1:0] o_quot
);

    localparam int NUM_BITS = WORD_BITS + FRAC_BITS;

    logic [WORD_BITS-1:0] c_rem  [NUM_BITS+1];
    logic [NUM_BITS-1:0]  c_num  [NUM_BITS+1];
    logic [NUM_BITS-1:0]  c_quot [NUM_BITS+1];
    logic [WORD_BITS-1:0] c_den  [NUM_BITS+1];

    logic [WORD_BITS-1:0] r_rem  [NUM_BITS];
    logic [NUM_BITS-1:0]  r_num  [NUM_BITS];
    logic [NUM_BITS-1:0]  r_quot [NUM_BITS];
    logic [WORD_BITS-1:0] r_den  [NUM_BITS];

    // The dividend is scaled by the fraction bits before dividing.
    assign c_rem[0]  = '0;
    assign c_num[0]  = {i_dividend, {FRAC_BITS{1'b0}}};
    assign c_quot[0] = '0;
    assign c_den[0]  = i_divisor;

    for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
        logic [WORD_BITS:0] shifted;
        logic [WORD_BITS:0] diff;
        logic               ge;

        assign shifted = {c_rem[k], c_num[k][NUM_BITS-1]};
        assign diff    = shifted - {1'b0, c_den[k]};
        assign ge      = shifted >= {1'b0, c_den[k]};

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
            r_num[k]  <= {c_num[k][NUM_BITS-2:0], 1'b0};
            r_quot[k] <= {c_quot[k][NUM_BITS-2:0], ge};
            r_den[k]  <= c_den[k];
        end

        assign c_rem[k+1]  = r_rem[k];
        assign c_num[k+1]  = r_num[k];
        assign c_quot[k+1] = r_quot[k];
        assign c_den[k+1]  = r_den[k];
    end

    assign o_quot = c_quot[NUM_BITS];

endmodule
